/* src/atps_pkg.sv */
// Shared types and constants for the aging trail point store.
package atps_pkg;

    localparam int POS_W   = 24;
    localparam int AGE_W   = 20;
    localparam int SIZE_W  = 16;
    localparam int TAG_W   = 32;
    localparam int HALF_W  = 16;
    localparam int DIST_W  = 23;
    localparam int IDX_W   = 6;
    localparam int ENTRY_W = 3 * POS_W + AGE_W + SIZE_W + TAG_W;

    localparam logic [AGE_W-1:0] AGE_SAT = {AGE_W{1'b1}};

    localparam logic [1:0] CFG_MAX_AGE  = 2'd0;
    localparam logic [1:0] CFG_MIN_DIST = 2'd1;
    localparam logic [1:0] CFG_GROUP    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AGE_RD,
        ST_AGE_WR,
        ST_HEAD_RD,
        ST_DIST,
        ST_DIST_ACC,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INSERT,
        ST_OUT_RD,
        ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [AGE_W-1:0]        age;
        logic [SIZE_W-1:0]       size;
        logic [TAG_W-1:0]        tag;
    } entry_t;

endpackage

/* src/atps_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module atps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/aging_trail_point_store_core.sv */
// Top level of the aging trail point store: sequencer, store memory and distance unit.
// One step ages and compacts the live entries, measures the head's distance if any is left,
// decides, shifts the store and inserts the new point if needed, then outputs each entry.
// Store contents are undefined after reset; only live entries are ever read.
// One input transaction is handled at a time; s_ready is low until the last result is taken.
// Synchronous active-low reset clears the live count, sequence number, state and working
// registers, and loads the configuration registers with their defaults.
module aging_trail_point_store_core #(
    parameter int MAX_POINTS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [22:0]                cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [23:0]         s_emit_x,
    input  logic signed [23:0]         s_emit_y,
    input  logic signed [23:0]         s_emit_z,
    input  logic [15:0]                s_time_step,
    input  logic [15:0]                s_point_size,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [5:0]                 m_out_index,
    output logic signed [23:0]         m_out_x,
    output logic signed [23:0]         m_out_y,
    output logic signed [23:0]         m_out_z,
    output logic [19:0]                m_out_age,
    output logic [15:0]                m_out_size,
    output logic [15:0]                m_out_group,
    output logic [15:0]                m_out_sequence,
    output logic                       m_inserted,
    output logic                       m_last_point
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] FULL_M1 = CW'(MAX_POINTS - 1);

    atps_pkg::state_t state_reg, state_next;

    logic [atps_pkg::AGE_W-1:0]  max_age_reg;
    logic [atps_pkg::DIST_W-1:0] min_dist_reg;
    logic [atps_pkg::HALF_W-1:0] group_reg;
    logic [CW-1:0]               live_reg, live_next;
    logic [atps_pkg::HALF_W-1:0] seq_reg, seq_next;
    logic [CW-1:0]               rd_reg, rd_next;
    logic [CW-1:0]               wr_reg, wr_next;
    logic [1:0]                  axis_reg, axis_next;
    logic [49:0]                 acc_reg, acc_next;
    logic [47:0]                 prod_reg;
    logic                        ins_reg, ins_next;

    logic signed [23:0]          ex_reg, ey_reg, ez_reg;
    logic [15:0]                 dt_reg, ps_reg;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    atps_pkg::entry_t            ram_wdata, ram_rdata;

    logic [20:0]                 age_sum;
    logic [atps_pkg::AGE_W-1:0]  age_new;
    logic signed [24:0]          diff;
    logic [23:0]                 mag;
    logic signed [23:0]          coord;
    logic signed [23:0]          ecoord;
    logic                        s_fire, m_fire;

    logic                        mv_reg;
    logic [5:0]                  oidx_reg;
    atps_pkg::entry_t            oent_reg;
    logic                        oins_reg, olast_reg;

    atps_ram #(.WIDTH(atps_pkg::ENTRY_W), .DEPTH(MAX_POINTS)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_fire = s_valid && s_ready;
    assign m_fire = mv_reg && m_ready;

    assign age_sum = {1'b0, ram_rdata.age} + {5'd0, dt_reg};
    assign age_new = age_sum[20] ? atps_pkg::AGE_SAT : age_sum[19:0];

    // One subtract-and-square unit shared by the three axes.
    always_comb begin
        case (axis_reg)
            2'd0:    begin coord = ram_rdata.x; ecoord = ex_reg; end
            2'd1:    begin coord = ram_rdata.y; ecoord = ey_reg; end
            default: begin coord = ram_rdata.z; ecoord = ez_reg; end
        endcase
        diff = 25'(ecoord) - 25'(coord);
        mag  = diff[24] ? 24'(-diff) : diff[23:0];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 48'(mag) * 48'(mag);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            atps_pkg::ST_IDLE:     if (s_fire) state_next = (live_reg == '0) ?
                                       atps_pkg::ST_DECIDE : atps_pkg::ST_AGE_RD;
            atps_pkg::ST_AGE_RD:   state_next = atps_pkg::ST_AGE_WR;
            atps_pkg::ST_AGE_WR:   state_next = (rd_reg + 1'b1 == live_reg) ?
                                       atps_pkg::ST_HEAD_RD : atps_pkg::ST_AGE_RD;
            atps_pkg::ST_HEAD_RD:  state_next = (wr_reg == '0) ?
                                       atps_pkg::ST_DECIDE : atps_pkg::ST_DIST;
            atps_pkg::ST_DIST:     state_next = atps_pkg::ST_DIST_ACC;
            atps_pkg::ST_DIST_ACC: state_next = (axis_reg == 2'd2) ?
                                       atps_pkg::ST_DECIDE : atps_pkg::ST_DIST;
            atps_pkg::ST_DECIDE:   state_next = atps_pkg::ST_SHIFT_RD;
            atps_pkg::ST_SHIFT_RD: state_next = (!ins_reg) ? atps_pkg::ST_OUT_RD :
                                       (wr_reg == '0) ? atps_pkg::ST_INSERT :
                                       atps_pkg::ST_SHIFT_WR;
            atps_pkg::ST_SHIFT_WR: state_next = atps_pkg::ST_SHIFT_RD;
            atps_pkg::ST_INSERT:   state_next = atps_pkg::ST_OUT_RD;
            atps_pkg::ST_OUT_RD:   state_next = atps_pkg::ST_OUT_WAIT;
            atps_pkg::ST_OUT_WAIT: if (!mv_reg || m_ready) begin
                state_next = (rd_reg + 1'b1 == live_reg) ? atps_pkg::ST_IDLE :
                             atps_pkg::ST_OUT_RD;
            end
            default:               state_next = atps_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        live_next = live_reg;
        seq_next  = seq_reg;
        rd_next   = rd_reg;
        wr_next   = wr_reg;
        axis_next = axis_reg;
        acc_next  = acc_reg;
        ins_next  = ins_reg;
        ram_we    = 1'b0;
        ram_waddr = wr_reg[AW-1:0];
        ram_raddr = rd_reg[AW-1:0];
        ram_wdata = ram_rdata;
        case (state_reg)
            atps_pkg::ST_IDLE: begin
                rd_next   = '0;
                wr_next   = '0;
                acc_next  = '0;
                axis_next = '0;
            end
            atps_pkg::ST_AGE_WR: begin
                ram_wdata.age = age_new;
                if (age_new < max_age_reg) begin
                    ram_we  = 1'b1;
                    wr_next = wr_reg + 1'b1;
                end
                rd_next = rd_reg + 1'b1;
                if (rd_reg + 1'b1 == live_reg) begin
                    ram_raddr = '0;
                end
            end
            atps_pkg::ST_HEAD_RD: begin
                // The compacted count becomes the live count; head is read now.
                ram_raddr = '0;
                live_next = wr_reg;
            end
            atps_pkg::ST_DIST: begin
                ram_raddr = '0;
            end
            atps_pkg::ST_DIST_ACC: begin
                ram_raddr = '0;
                acc_next  = acc_reg + 50'(prod_reg);
                axis_next = axis_reg + 2'd1;
            end
            atps_pkg::ST_DECIDE: begin
                ins_next = (live_reg == '0) ||
                           (acc_reg >= 50'(46'(min_dist_reg) * 46'(min_dist_reg)));
                // Shift source is the last entry that survives the insertion.
                if (live_reg < FULL_M1) begin
                    wr_next = live_reg;
                end else begin
                    wr_next = FULL_M1;
                end
                rd_next = ((live_reg < FULL_M1) ? live_reg : FULL_M1) - 1'b1;
            end
            atps_pkg::ST_SHIFT_RD: begin
                if (!ins_reg || wr_reg == '0) begin
                    rd_next = '0;
                end
            end
            atps_pkg::ST_SHIFT_WR: begin
                ram_we  = 1'b1;
                wr_next = wr_reg - 1'b1;
                rd_next = rd_reg - 1'b1;
                if (wr_reg == CW'(1)) begin
                    rd_next = '0;
                end
            end
            atps_pkg::ST_INSERT: begin
                ram_we        = 1'b1;
                ram_waddr     = '0;
                ram_wdata.x   = ex_reg;
                ram_wdata.y   = ey_reg;
                ram_wdata.z   = ez_reg;
                ram_wdata.age = '0;
                ram_wdata.size = ps_reg;
                ram_wdata.tag = {group_reg, seq_reg};
                seq_next      = seq_reg + 1'b1;
                live_next     = ((live_reg < FULL_M1) ? live_reg : FULL_M1) + 1'b1;
                rd_next       = '0;
            end
            atps_pkg::ST_OUT_WAIT: begin
                if (!mv_reg || m_ready) begin
                    rd_next = rd_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= atps_pkg::ST_IDLE;
            max_age_reg  <= 20'd1024;
            min_dist_reg <= 23'd256;
            group_reg    <= '0;
            live_reg     <= '0;
            seq_reg      <= '0;
            rd_reg       <= '0;
            wr_reg       <= '0;
            axis_reg     <= '0;
            acc_reg      <= '0;
            ins_reg      <= 1'b0;
            mv_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            live_reg  <= live_next;
            seq_reg   <= seq_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
            axis_reg  <= axis_next;
            acc_reg   <= acc_next;
            ins_reg   <= ins_next;
            if (cfg_we) begin
                case (cfg_index)
                    atps_pkg::CFG_MAX_AGE:  max_age_reg  <= cfg_data[19:0];
                    atps_pkg::CFG_MIN_DIST: min_dist_reg <= cfg_data;
                    atps_pkg::CFG_GROUP:    group_reg    <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (state_reg == atps_pkg::ST_OUT_WAIT && (!mv_reg || m_ready)) begin
                mv_reg <= 1'b1;
            end else if (m_fire) begin
                mv_reg <= 1'b0;
            end
        end
    end

    // Input capture and output register; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ex_reg <= s_emit_x;
            ey_reg <= s_emit_y;
            ez_reg <= s_emit_z;
            dt_reg <= s_time_step;
            ps_reg <= s_point_size;
        end
        if (state_reg == atps_pkg::ST_OUT_WAIT && (!mv_reg || m_ready)) begin
            oidx_reg  <= 6'(rd_reg);
            oent_reg  <= ram_rdata;
            oins_reg  <= ins_reg;
            olast_reg <= (rd_reg + 1'b1 == live_reg);
        end
    end

    assign s_ready        = (state_reg == atps_pkg::ST_IDLE) && !mv_reg;
    assign m_valid        = mv_reg;
    assign m_out_index    = oidx_reg;
    assign m_out_x        = oent_reg.x;
    assign m_out_y        = oent_reg.y;
    assign m_out_z        = oent_reg.z;
    assign m_out_age      = oent_reg.age;
    assign m_out_size     = oent_reg.size;
    assign m_out_group    = oent_reg.tag[31:16];
    assign m_out_sequence = oent_reg.tag[15:0];
    assign m_inserted     = oins_reg;
    assign m_last_point   = olast_reg;
endmodule

/* tb/tb_aging_trail_point_store_core.sv */
// Self-checking testbench for the aging trail point store core.
module tb_aging_trail_point_store_core;

    localparam int NPTS = 32;
    localparam int CYCLE_LIMIT = 2000000;
    // Register index past the last register; writes to it are ignored.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = atps_pkg::CFG_MAX_AGE;
    logic [22:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [23:0] s_emit_x = '0, s_emit_y = '0, s_emit_z = '0;
    logic [15:0] s_time_step = '0, s_point_size = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [5:0] m_out_index;
    logic signed [23:0] m_out_x, m_out_y, m_out_z;
    logic [19:0] m_out_age;
    logic [15:0] m_out_size, m_out_group, m_out_sequence;
    logic m_inserted, m_last_point;

    typedef struct packed {
        logic [5:0] index;
        logic signed [23:0] x, y, z;
        logic [19:0] age;
        logic [15:0] size, group, seq_no;
        logic inserted, last;
    } point_rec_t;

    point_rec_t trail_q[$];
    atps_pkg::entry_t trail[NPTS];
    int trail_len;
    logic [15:0] seq_next;
    logic [19:0] age_limit;
    logic [22:0] seg_dist;
    logic [15:0] group_tag;

    int errors = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;

    always #4 aclk = ~aclk;

    aging_trail_point_store_core #(.MAX_POINTS(NPTS)) dut (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver readiness.
    always @(posedge aclk) begin
        if (hold_off) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compares each result transaction with the oldest predicted point.
    always @(posedge aclk) begin
        point_rec_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_out_index, m_out_x, m_out_y, m_out_z, m_out_age, m_out_size,
                    m_out_group, m_out_sequence, m_inserted, m_last_point};
            if (trail_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected point %h", $time, got);
            end else begin
                want = trail_q.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: point mismatch expected %h actual %h", $time, want, got);
                end
            end
        end
    end

    function automatic logic [63:0] sq_delta(logic signed [23:0] a, logic signed [23:0] b);
        logic signed [25:0] d;
        d = 26'(a) - 26'(b);
        if (d < 0) d = -d;
        return 64'(d) * 64'(d);
    endfunction

    // Ages, compacts, maybe inserts, then queues the whole list.
    task automatic predict_trail(logic signed [23:0] ex, logic signed [23:0] ey,
                                 logic signed [23:0] ez, logic [15:0] dt,
                                 logic [15:0] psize);
        int kept;
        logic [20:0] a;
        bit ins;
        logic [63:0] d2;
        point_rec_t r;
        kept = 0;
        ins = 1'b1;
        for (int i = 0; i < trail_len; i++) begin
            a = 21'(trail[i].age) + 21'(dt);
            trail[i].age = a[20] ? atps_pkg::AGE_SAT : a[19:0];
            if (trail[i].age < age_limit) begin
                trail[kept] = trail[i];
                kept++;
            end
        end
        trail_len = kept;
        if (trail_len > 0) begin
            d2 = sq_delta(ex, trail[0].x) + sq_delta(ey, trail[0].y)
                + sq_delta(ez, trail[0].z);
            if (d2 < 64'(seg_dist) * 64'(seg_dist)) ins = 1'b0;
        end
        if (ins) begin
            if (trail_len > NPTS - 1) trail_len = NPTS - 1;
            for (int i = trail_len; i > 0; i--) trail[i] = trail[i-1];
            trail[0] = '{ex, ey, ez, 20'd0, psize, {group_tag, seq_next}};
            seq_next++;
            trail_len++;
        end
        for (int i = 0; i < trail_len; i++) begin
            r = '{6'(i), trail[i].x, trail[i].y, trail[i].z, trail[i].age, trail[i].size,
                  trail[i].tag[31:16], trail[i].tag[15:0], ins, i == trail_len - 1};
            trail_q = {trail_q, r};
        end
    endtask

    task automatic send_step(logic signed [23:0] ex, logic signed [23:0] ey,
                             logic signed [23:0] ez, logic [15:0] dt, logic [15:0] psize);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_valid <= 1'b1;
        s_emit_x <= ex;
        s_emit_y <= ey;
        s_emit_z <= ez;
        s_time_step <= dt;
        s_point_size <= psize;
        do @(posedge aclk); while (!s_ready);
        predict_trail(ex, ey, ez, dt, psize);
        s_valid <= 1'b0;
        // The core is busy after a transaction, so this costs no rate.
        @(posedge aclk);
    endtask

    task automatic drain;
        while (trail_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [22:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            atps_pkg::CFG_MAX_AGE:  age_limit = val[19:0];
            atps_pkg::CFG_MIN_DIST: seg_dist = val;
            atps_pkg::CFG_GROUP:    group_tag = val[15:0];
            default:                ;
        endcase
        @(posedge aclk);
    endtask

    function automatic logic signed [23:0] rand_pos();
        return 24'($urandom);
    endfunction

    task automatic test_directed;
        send_step(24'sh7FFFFF, 24'sh800000, 24'sd0, 16'd0, 16'hFFFF);
        send_step(24'sh7FFFFF, 24'sh800000, 24'sd0, 16'd1, 16'd1);
        send_step(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 16'd10, 16'd0);
        send_step(24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF + 24'sd0, 16'hFFFF, 16'd5);
        drain();
        write_reg(atps_pkg::CFG_GROUP, 23'h00FFFF);
        write_reg(atps_pkg::CFG_MAX_AGE, 23'h0FFFFF);
        write_reg(atps_pkg::CFG_MIN_DIST, 23'd0);
        for (int i = 0; i < 10; i++) send_step(rand_pos(), rand_pos(), rand_pos(), 16'hFFFF, 16'(i));
        drain();
        write_reg(atps_pkg::CFG_MAX_AGE, 23'd0);
        send_step(24'sd5, 24'sd5, 24'sd5, 16'd0, 16'd3);
        send_step(24'sd5, 24'sd5, 24'sd5, 16'd0, 16'd4);
        drain();
        write_reg(atps_pkg::CFG_MAX_AGE, 23'h0FFFFF);
        write_reg(atps_pkg::CFG_MIN_DIST, 23'h7FFFFF);
        write_reg(atps_pkg::CFG_GROUP, 23'h000000);
        send_step(24'sd0, 24'sd0, 24'sd0, 16'd1, 16'd9);
        send_step(24'sd0, 24'sd0, 24'sd0, 16'd1, 16'd9);
        drain();
        write_reg(CFG_UNUSED, 23'h7FFFFF);
        drain();
    endtask

    // Fills the store past capacity, with the receiver holding off at the start.
    task automatic test_overflow_pressure;
        write_reg(atps_pkg::CFG_MAX_AGE, 23'h0FFFFF);
        write_reg(atps_pkg::CFG_MIN_DIST, 23'd1);
        write_reg(atps_pkg::CFG_GROUP, 23'h00A5A5);
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 40; i++)
                send_step(24'(i * 3), rand_pos(), 24'(-i), 16'($urandom_range(8)), 16'($urandom));
        join
        drain();
    endtask

    task automatic test_random(int idle_pct, int stall_pct, int n);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        write_reg(atps_pkg::CFG_MAX_AGE, 23'($urandom_range(2000, 60000)));
        write_reg(atps_pkg::CFG_MIN_DIST, 23'($urandom_range(0, 3000)));
        write_reg(atps_pkg::CFG_GROUP, 23'($urandom_range(65535)));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 7) begin
                // Short moves near the head, mixed around the distance threshold.
                send_step(24'($urandom_range(4000)) - 24'sd2000,
                          24'($urandom_range(4000)) - 24'sd2000,
                          24'($urandom_range(4000)) - 24'sd2000,
                          16'($urandom_range(3000)), 16'($urandom));
            end else begin
                send_step(rand_pos(), rand_pos(), rand_pos(), 16'($urandom), 16'($urandom));
            end
        end
        drain();
    endtask

    initial begin
        age_limit = 20'd1024;
        seg_dist = 23'd256;
        group_tag = 16'd0;
        seq_next = 16'd0;
        trail_len = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_overflow_pressure();
        test_random(0, 0, 12);
        test_random(57, 0, 12);
        test_random(0, 57, 12);
        test_random(19, 19, 12);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* filelist.f */
src/atps_pkg.sv
src/atps_ram.sv
src/aging_trail_point_store_core.sv
tb/tb_aging_trail_point_store_core.sv
